[rtl/core/mag_rotation_gated_soft_iron_scale_top_assert.svh]
// Assertion macros shared by the calibration core and its gain divider.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef MAG_ROTATION_GATED_SOFT_IRON_SCALE_TOP_ASSERT_SVH
`define MAG_ROTATION_GATED_SOFT_IRON_SCALE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MRGSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRGSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mrgsi_pkg.sv]
package mrgsi_pkg;

    // Field and datapath widths
    localparam int FIELD_W = 16;
    localparam int SCALE_W = 15;
    localparam int SPAN_W  = FIELD_W + 1;
    localparam int TOTAL_W = SPAN_W + 2;
    localparam int AXES    = 3;

    // Command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Axis index of the last axis
    localparam logic [1:0] LAST_AXIS = 2'd2;

    // Calibration state reset values
    localparam logic signed [FIELD_W-1:0] PREV_RESET     = 16'sd0;
    localparam logic signed [FIELD_W-1:0] AXIS_MIN_RESET = 16'sh7FFF;
    localparam logic signed [FIELD_W-1:0] AXIS_MAX_RESET = 16'sh8000;

    // Gain format: Q3.12, unity and saturation limit
    localparam logic [SCALE_W-1:0] UNITY_GAIN = 15'd4096;
    localparam logic [SCALE_W-1:0] GAIN_LIMIT = 15'd32767;
    localparam logic [SCALE_W-1:0] GAIN_ZERO  = 15'd0;
    localparam int                 GAIN_FRAC  = 12;

    // Rotation gate: 10000 * D > 49 * S
    localparam int               GATE_D_W      = 14;
    localparam int               GATE_S_W      = 6;
    localparam logic [GATE_D_W-1:0] GATE_D_WEIGHT = 14'd10000;
    localparam logic [GATE_S_W-1:0] GATE_S_WEIGHT = 6'd49;

    // Serial step counts (one bit per cycle)
    localparam int SQUARE_STEPS = FIELD_W;
    localparam int MUL_STEPS    = GATE_D_W;
    localparam int DIV_STEPS    = SCALE_W + 1;

    // Input and output transactions
    typedef struct packed {
        logic                      command;
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
    } sample_t;

    typedef struct packed {
        logic               accepted;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
        logic [SCALE_W-1:0] scale_z;
    } result_t;

    // Gain divider request and response
    typedef struct packed {
        logic               start;
        logic [SPAN_W-1:0]  span;   // two's complement
        logic [TOTAL_W-1:0] total;  // two's complement
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] gain;
    } div_rsp_t;

endpackage

[rtl/core/mrgsi_gain_div.sv]
`include "mag_rotation_gated_soft_iron_scale_top_assert.svh"

// Soft-iron gain of one axis: round-half-even(4096 * total / (3 * span)),
// saturated, by restoring division one quotient bit per cycle.
module mrgsi_gain_div
    import mrgsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DEN_W = FIELD_W + 2;
    localparam int NUM_W = TOTAL_W - 1 + GAIN_FRAC;
    localparam int SH_W  = DEN_W + DIV_STEPS - 1;
    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {DV_IDLE, DV_STEP, DV_ROUND, DV_DONE} dv_state_t;

    dv_state_t          state_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [SH_W-1:0]    den_sh_reg;
    logic [DIV_STEPS-1:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SCALE_W-1:0] gain_reg;

    logic               span_low;
    logic [DEN_W-1:0]   den3;
    logic               ge;
    logic [DEN_W:0]     two_r;
    logic               round_up;
    logic [DIV_STEPS:0] q_up;
    logic               sat;

    // Span below one means the axis has no range yet
    assign span_low = req.span[SPAN_W-1] || (req.span == '0);
    assign den3     = {2'b00, req.span[FIELD_W-1:0]} + {1'b0, req.span[FIELD_W-1:0], 1'b0};

    // Restoring step compare
    assign ge = {{(SH_W-NUM_W){1'b0}}, rem_reg} >= den_sh_reg;

    // Round half to even on the final remainder
    assign two_r    = {rem_reg[DEN_W-1:0], 1'b0};
    assign round_up = (two_r > {1'b0, den_reg}) || ((two_r == {1'b0, den_reg}) && q_reg[0]);
    assign q_up     = {1'b0, q_reg} + {{DIV_STEPS{1'b0}}, round_up};
    assign sat      = q_reg[DIV_STEPS-1] || q_up[DIV_STEPS-1] || q_up[DIV_STEPS];

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= DV_IDLE;
            rem_reg    <= '0;
            den_reg    <= '0;
            den_sh_reg <= '0;
            q_reg      <= '0;
            cnt_reg    <= '0;
            gain_reg   <= UNITY_GAIN;
        end
        else
        begin
            case (state_reg)
                DV_IDLE:
                begin
                    if (req.start)
                    begin
                        if (span_low)
                        begin
                            gain_reg  <= UNITY_GAIN;
                            state_reg <= DV_DONE;
                        end
                        else if (req.total[TOTAL_W-1])
                        begin
                            gain_reg  <= GAIN_ZERO;
                            state_reg <= DV_DONE;
                        end
                        else
                        begin
                            rem_reg    <= {req.total[TOTAL_W-2:0], {GAIN_FRAC{1'b0}}};
                            den_reg    <= den3;
                            den_sh_reg <= {den3, {(DIV_STEPS-1){1'b0}}};
                            q_reg      <= '0;
                            cnt_reg    <= '0;
                            state_reg  <= DV_STEP;
                        end
                    end
                end
                DV_STEP:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - den_sh_reg[NUM_W-1:0];
                    end
                    q_reg      <= {q_reg[DIV_STEPS-2:0], ge};
                    den_sh_reg <= den_sh_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= DV_ROUND;
                    end
                end
                DV_ROUND:
                begin
                    gain_reg  <= sat ? GAIN_LIMIT : q_up[SCALE_W-1:0];
                    state_reg <= DV_DONE;
                end
                DV_DONE:
                begin
                    state_reg <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == DV_DONE);
    assign rsp.gain = gain_reg;

    `MRGSI_ASSERT_NOW(a_start_only_idle, req.start, state_reg == DV_IDLE, "divider started while busy")
    `MRGSI_ASSERT_NEXT(a_done_single, rsp.done, !rsp.done, "divider done held past one cycle")
    `MRGSI_ASSERT_NOW(a_first_step_after_start, (state_reg == DV_STEP) && (cnt_reg == '0), $past(req.start), "division began without a start")

endmodule

[rtl/core/mag_rotation_gated_soft_iron_scale_top.sv]
// Rotation-gated min/max soft-iron calibration for a three-axis magnetometer.
// A sample (command 0) is recorded only when it has turned far enough from the
// last recorded point: 10000*sum(n-p)^2 > 49*sum(n+p)^2 with a nonzero right
// side, computed exactly. A recorded sample widens the per-axis min/max and
// becomes the new reference point. A restart (command 1) clears min, max and
// the reference point. Every transaction returns one result: the accepted
// flag and three Q3.12 gains, round-half-even(4096*total_span/(3*span)),
// saturated to 32767, or 4096 for an axis with no positive span. The squares
// and gate products are formed by bit-serial shift-add, one bit per cycle, and
// the gains by a shared restoring divider, one quotient bit per cycle, run
// three times. After a sample is taken the input stays stalled through the
// squares, the gate products, the gate, the three gains and the output load,
// so no new sample is taken before the last one is through; a restart stalls
// it through the three gains and the output load. Axes without a positive
// span skip the division. A new transaction is taken while the last result
// still waits in the output register; the output load waits while a stalled
// result still occupies it.
`include "mag_rotation_gated_soft_iron_scale_top_assert.svh"

module mag_rotation_gated_soft_iron_scale_top
    import mrgsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int SQ_W   = 2 * FIELD_W;
    localparam int ACC_W  = SQ_W + 2;
    localparam int P_W    = ACC_W + GATE_D_W;
    localparam int Q_W    = ACC_W + GATE_S_W;
    localparam int STEP_W = $clog2(SQUARE_STEPS > MUL_STEPS ? SQUARE_STEPS : MUL_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_LOAD,
        ST_SQ_STEP,
        ST_MUL_LOAD,
        ST_MUL_STEP,
        ST_GATE,
        ST_DIV_LAUNCH,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    sample_t                   sample_reg;
    logic [1:0]                axis_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [FIELD_W-1:0] prev_reg [AXES];
    logic signed [FIELD_W-1:0] min_reg  [AXES];
    logic signed [FIELD_W-1:0] max_reg  [AXES];
    logic [FIELD_W-1:0]        dmag_reg;
    logic [FIELD_W-1:0]        smag_reg;
    logic [SQ_W-1:0]           dmc_reg;
    logic [SQ_W-1:0]           smc_reg;
    logic [ACC_W-1:0]          d_acc_reg;
    logic [ACC_W-1:0]          s_acc_reg;
    logic [P_W-1:0]            d_sh_reg;
    logic [Q_W-1:0]            s_sh_reg;
    logic [P_W-1:0]            p_acc_reg;
    logic [Q_W-1:0]            q_acc_reg;
    logic [GATE_D_W-1:0]       kd_reg;
    logic [GATE_S_W-1:0]       ks_reg;
    logic                      accepted_reg;
    logic [SCALE_W-1:0]        scale_reg [AXES];
    logic                      result_valid_reg;
    result_t                   result_reg;

    logic signed [FIELD_W-1:0] smp [AXES];
    logic signed [FIELD_W-1:0] field_sel;
    logic signed [FIELD_W-1:0] prev_sel;
    logic [SPAN_W-1:0]         diff;
    logic [SPAN_W-1:0]         sum;
    logic [SPAN_W-1:0]         diff_abs;
    logic [SPAN_W-1:0]         sum_abs;
    logic [SPAN_W-1:0]         span [AXES];
    logic [TOTAL_W-1:0]        total;
    logic                      gate_ok;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    // Sample fields as an axis-indexed array
    assign smp[0] = sample_reg.field_x;
    assign smp[1] = sample_reg.field_y;
    assign smp[2] = sample_reg.field_z;

    // Difference and sum against the reference point for the current axis
    assign field_sel = smp[axis_reg];
    assign prev_sel  = prev_reg[axis_reg];
    assign diff      = {field_sel[FIELD_W-1], field_sel} - {prev_sel[FIELD_W-1], prev_sel};
    assign sum       = {field_sel[FIELD_W-1], field_sel} + {prev_sel[FIELD_W-1], prev_sel};
    assign diff_abs  = diff[SPAN_W-1] ? (~diff + 1'b1) : diff;
    assign sum_abs   = sum[SPAN_W-1] ? (~sum + 1'b1) : sum;

    // Spans and their sum from the stored extremes
    always_comb
    begin
        total = '0;
        for (int i = 0; i < AXES; i++)
        begin
            span[i] = {max_reg[i][FIELD_W-1], max_reg[i]} - {min_reg[i][FIELD_W-1], min_reg[i]};
            total   = total + {{(TOTAL_W-SPAN_W){span[i][SPAN_W-1]}}, span[i]};
        end
    end

    // Rotation gate decision
    assign gate_ok = (s_acc_reg != '0) && (p_acc_reg > {{(P_W-Q_W){1'b0}}, q_acc_reg});

    // Gain divider, shared by the three axes
    assign div_req.start = (state_reg == ST_DIV_LAUNCH);
    assign div_req.span  = span[axis_reg];
    assign div_req.total = total;

    mrgsi_gain_div u_gain_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer, calibration state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_reg       <= '0;
            axis_reg         <= '0;
            step_reg         <= '0;
            dmag_reg         <= '0;
            smag_reg         <= '0;
            dmc_reg          <= '0;
            smc_reg          <= '0;
            d_acc_reg        <= '0;
            s_acc_reg        <= '0;
            d_sh_reg         <= '0;
            s_sh_reg         <= '0;
            p_acc_reg        <= '0;
            q_acc_reg        <= '0;
            kd_reg           <= '0;
            ks_reg           <= '0;
            accepted_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                prev_reg[i]  <= PREV_RESET;
                min_reg[i]   <= AXIS_MIN_RESET;
                max_reg[i]   <= AXIS_MAX_RESET;
                scale_reg[i] <= UNITY_GAIN;
            end
        end
        else
        begin
            // Output register drains independently of the sequencer;
            // the finish state handles the valid flag itself
            if (result_valid_reg && !result_stall && (state_reg != ST_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        sample_reg <= sample;
                        axis_reg   <= '0;
                        d_acc_reg  <= '0;
                        s_acc_reg  <= '0;
                        if (sample.command == CMD_RESTART)
                        begin
                            accepted_reg <= 1'b0;
                            for (int i = 0; i < AXES; i++)
                            begin
                                prev_reg[i] <= PREV_RESET;
                                min_reg[i]  <= AXIS_MIN_RESET;
                                max_reg[i]  <= AXIS_MAX_RESET;
                            end
                            state_reg <= ST_DIV_LAUNCH;
                        end
                        else
                        begin
                            state_reg <= ST_SQ_LOAD;
                        end
                    end
                end
                ST_SQ_LOAD:
                begin
                    dmag_reg  <= diff_abs[FIELD_W-1:0];
                    smag_reg  <= sum_abs[FIELD_W-1:0];
                    dmc_reg   <= {{FIELD_W{1'b0}}, diff_abs[FIELD_W-1:0]};
                    smc_reg   <= {{FIELD_W{1'b0}}, sum_abs[FIELD_W-1:0]};
                    // Sum magnitude 65536 (both at full negative scale) does not
                    // fit the serial operand, so its square goes in directly
                    if (sum_abs[FIELD_W])
                    begin
                        s_acc_reg <= s_acc_reg + {2'b01, {SQ_W{1'b0}}};
                    end
                    step_reg  <= '0;
                    state_reg <= ST_SQ_STEP;
                end
                ST_SQ_STEP:
                begin
                    // One multiplier bit per cycle for both squares
                    if (dmag_reg[0])
                    begin
                        d_acc_reg <= d_acc_reg + {2'b00, dmc_reg};
                    end
                    if (smag_reg[0])
                    begin
                        s_acc_reg <= s_acc_reg + {2'b00, smc_reg};
                    end
                    dmag_reg <= dmag_reg >> 1;
                    smag_reg <= smag_reg >> 1;
                    dmc_reg  <= dmc_reg << 1;
                    smc_reg  <= smc_reg << 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SQUARE_STEPS - 1))
                    begin
                        if (axis_reg == LAST_AXIS)
                        begin
                            state_reg <= ST_MUL_LOAD;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_SQ_LOAD;
                        end
                    end
                end
                ST_MUL_LOAD:
                begin
                    d_sh_reg  <= {{(P_W-ACC_W){1'b0}}, d_acc_reg};
                    s_sh_reg  <= {{(Q_W-ACC_W){1'b0}}, s_acc_reg};
                    p_acc_reg <= '0;
                    q_acc_reg <= '0;
                    kd_reg    <= GATE_D_WEIGHT;
                    ks_reg    <= GATE_S_WEIGHT;
                    step_reg  <= '0;
                    state_reg <= ST_MUL_STEP;
                end
                ST_MUL_STEP:
                begin
                    // Constant weights applied one bit per cycle
                    if (kd_reg[0])
                    begin
                        p_acc_reg <= p_acc_reg + d_sh_reg;
                    end
                    if (ks_reg[0])
                    begin
                        q_acc_reg <= q_acc_reg + s_sh_reg;
                    end
                    kd_reg   <= kd_reg >> 1;
                    ks_reg   <= ks_reg >> 1;
                    d_sh_reg <= d_sh_reg << 1;
                    s_sh_reg <= s_sh_reg << 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MUL_STEPS - 1))
                    begin
                        state_reg <= ST_GATE;
                    end
                end
                ST_GATE:
                begin
                    accepted_reg <= gate_ok;
                    if (gate_ok)
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            if (smp[i] < min_reg[i])
                            begin
                                min_reg[i] <= smp[i];
                            end
                            if (smp[i] > max_reg[i])
                            begin
                                max_reg[i] <= smp[i];
                            end
                            prev_reg[i] <= smp[i];
                        end
                    end
                    axis_reg  <= '0;
                    state_reg <= ST_DIV_LAUNCH;
                end
                ST_DIV_LAUNCH:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        scale_reg[axis_reg] <= div_rsp.gain;
                        if (axis_reg == LAST_AXIS)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_DIV_LAUNCH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    // Load the output register once it is free
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.accepted <= accepted_reg;
                        result_reg.scale_x  <= scale_reg[0];
                        result_reg.scale_y  <= scale_reg[1];
                        result_reg.scale_z  <= scale_reg[2];
                        result_valid_reg    <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `MRGSI_ASSERT_NOW(a_axes_agree, 1'b1, ((min_reg[0] <= max_reg[0]) == (min_reg[1] <= max_reg[1])) && ((min_reg[1] <= max_reg[1]) == (min_reg[2] <= max_reg[2])), "axes disagree on calibration state")
    `MRGSI_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "block idle right after a transaction")
    `MRGSI_ASSERT_NOW(a_result_from_finish, $rose(result_valid_reg), $past(state_reg == ST_FINISH), "result loaded outside finish")

endmodule
